### rtl/core/ssfa_pkg.sv
// Shared types, codes and constants of the steering pipeline.
`default_nettype none

package ssfa_pkg;

    // Command codes
    localparam logic [1:0] CMD_SEEK   = 2'd0;
    localparam logic [1:0] CMD_FLEE   = 2'd1;
    localparam logic [1:0] CMD_ARRIVE = 2'd2;

    // Configuration register indexes
    localparam logic REG_ARRIVE_RADIUS = 1'b0;
    localparam logic REG_ARRIVE_GAIN   = 1'b1;

    // Register reset values: radius 2.0, gain 4.0 in Q16.16
    localparam logic [30:0] RADIUS_RESET = 31'd131072;
    localparam logic [30:0] GAIN_RESET   = 31'd262144;

    // Root and quotient widths of the length normalizer
    localparam int ROOT_BITS = 31;
    localparam int QUOT_BITS = 31;
    localparam int WIDE_BITS = 62;

    // Heading unit: angle in units of 2^-21 rad
    localparam int CORDIC_STEPS = 21;
    localparam int ANG_BITS     = 26;
    localparam int CX_BITS      = 45;
    localparam logic signed [ANG_BITS-1:0] PI_ANG   = 26'sd6588397;
    localparam logic signed [15:0]         HEAD_MAX = 16'sd25736;

    // Control carried from the front end into the length normalizer
    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        use_scale;
        logic        use_w;
        logic        in_radius;
        logic [30:0] speed;
        logic [30:0] wx;
        logic [30:0] wy;
        logic [15:0] head;
    } ctrl_t;

    // Velocity result carried into the heading unit
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [15:0]        head;
        logic               in_radius;
    } res_t;

    // atan(2^-i) in units of 2^-21 rad
    function automatic logic [22:0] atan_entry(input int i);
        logic [22:0] r;
        case (i)
            0:       r = 23'd1647099;
            1:       r = 23'd972340;
            2:       r = 23'd513757;
            3:       r = 23'd260791;
            4:       r = 23'd130902;
            5:       r = 23'd65515;
            6:       r = 23'd32765;
            7:       r = 23'd16384;
            8:       r = 23'd8192;
            9:       r = 23'd4096;
            10:      r = 23'd2048;
            11:      r = 23'd1024;
            12:      r = 23'd512;
            13:      r = 23'd256;
            14:      r = 23'd128;
            15:      r = 23'd64;
            16:      r = 23'd32;
            17:      r = 23'd16;
            18:      r = 23'd8;
            19:      r = 23'd4;
            20:      r = 23'd2;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ssfa_front.sv
// Front end: offset, arrive radius test, gain scaling and clamp decision (6 stages).
`default_nettype none

module ssfa_front #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          cmd,
    input  wire logic signed [W-1:0] ax,
    input  wire logic signed [W-1:0] ay,
    input  wire logic signed [W-1:0] tx,
    input  wire logic signed [W-1:0] ty,
    input  wire logic [30:0]         speed,
    input  wire logic [15:0]         head,
    input  wire logic [30:0]         radius,
    input  wire logic [30:0]         gain,
    output logic                     out_valid,
    output ssfa_pkg::ctrl_t          out_ctrl,
    output logic [W:0]               out_a,
    output logic [W:0]               out_b
);
    import ssfa_pkg::*;

    localparam int MW = W + 1;
    localparam int CW = (MW > 32) ? MW : 32;
    localparam int WW = MW + 16;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [30:0]   speed;
        logic [15:0]   head;
        logic          sx;
        logic          sy;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
    } carry_t;

    logic [5:0]           vld_reg;
    logic [1:0]           cmd1_reg;
    logic [30:0]          speed1_reg;
    logic [15:0]          head1_reg;
    logic signed [MW-1:0] dx1_reg;
    logic signed [MW-1:0] dy1_reg;
    carry_t               carry_reg [2:5];
    carry_t               carry2_next;

    logic                 ltx3_reg, lty3_reg;
    logic [61:0]          sqa3_reg, sqb3_reg, sqr3_reg;
    logic [WW-1:0]        phx3_reg, phy3_reg;
    logic [30:0]          plx3_reg, ply3_reg;
    logic [30:0]          a_lo, b_lo;

    logic                 inside4_reg, inside5_reg;
    logic [30:0]          wx4_reg, wy4_reg, wx5_reg, wy5_reg;
    logic                 gtx4_reg, gty4_reg, gtx5_reg, gty5_reg;
    logic [WW-1:0]        wx_full, wy_full;
    logic                 inside_next;

    logic [61:0]          wx25_reg, wy25_reg, s25_reg;
    logic                 clamp;
    logic                 arrive5;

    ctrl_t                ctrl_next;
    ctrl_t                ctrl6_reg;
    logic [MW-1:0]        a6_reg, b6_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Stage 2: magnitudes and effective signs (flee turns the offset around)
    always_comb
    begin
        carry2_next.cmd   = cmd1_reg;
        carry2_next.speed = speed1_reg;
        carry2_next.head  = head1_reg;
        carry2_next.a     = dx1_reg[MW-1] ? $unsigned(-dx1_reg) : $unsigned(dx1_reg);
        carry2_next.b     = dy1_reg[MW-1] ? $unsigned(-dy1_reg) : $unsigned(dy1_reg);
        if (cmd1_reg == CMD_FLEE)
        begin
            carry2_next.sx = !dx1_reg[MW-1] && (dx1_reg != '0);
            carry2_next.sy = !dy1_reg[MW-1] && (dy1_reg != '0);
        end
        else
        begin
            carry2_next.sx = dx1_reg[MW-1];
            carry2_next.sy = dy1_reg[MW-1];
        end
    end

    // Stage 3 operands: low bits only matter when below the radius
    assign a_lo = 31'(carry_reg[2].a);
    assign b_lo = 31'(carry_reg[2].b);

    // Stage 4: radius test and gain sums
    assign wx_full = phx3_reg + WW'(plx3_reg);
    assign wy_full = phy3_reg + WW'(ply3_reg);
    assign inside_next = (carry_reg[3].cmd == CMD_ARRIVE) && ltx3_reg && lty3_reg &&
                         ((63'(sqa3_reg) + 63'(sqb3_reg)) < 63'(sqr3_reg));

    // Stage 6: clamp decision and path select
    assign clamp   = gtx5_reg || gty5_reg ||
                     ((63'(wx25_reg) + 63'(wy25_reg)) > 63'(s25_reg));
    assign arrive5 = (carry_reg[5].cmd == CMD_ARRIVE);

    always_comb
    begin
        ctrl_next.sx        = carry_reg[5].sx;
        ctrl_next.sy        = carry_reg[5].sy;
        ctrl_next.use_scale = (carry_reg[5].cmd == CMD_SEEK) ||
                              (carry_reg[5].cmd == CMD_FLEE) ||
                              (arrive5 && !inside5_reg && clamp);
        ctrl_next.use_w     = arrive5 && !inside5_reg && !clamp;
        ctrl_next.in_radius = inside5_reg;
        ctrl_next.speed     = carry_reg[5].speed;
        ctrl_next.wx        = wx5_reg;
        ctrl_next.wy        = wy5_reg;
        ctrl_next.head      = carry_reg[5].head;
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        // stage 1: offsets
        cmd1_reg   <= cmd;
        speed1_reg <= speed;
        head1_reg  <= head;
        dx1_reg    <= MW'(tx) - MW'(ax);
        dy1_reg    <= MW'(ty) - MW'(ay);
        // stage 2
        carry_reg[2] <= carry2_next;
        // stage 3: squares and gain partial products
        carry_reg[3] <= carry_reg[2];
        ltx3_reg <= CW'(carry_reg[2].a) < CW'(radius);
        lty3_reg <= CW'(carry_reg[2].b) < CW'(radius);
        sqa3_reg <= 62'(a_lo) * 62'(a_lo);
        sqb3_reg <= 62'(b_lo) * 62'(b_lo);
        sqr3_reg <= 62'(radius) * 62'(radius);
        phx3_reg <= WW'(carry_reg[2].a >> 16) * WW'(gain);
        phy3_reg <= WW'(carry_reg[2].b >> 16) * WW'(gain);
        plx3_reg <= 31'((47'(carry_reg[2].a[15:0]) * 47'(gain)) >> 16);
        ply3_reg <= 31'((47'(carry_reg[2].b[15:0]) * 47'(gain)) >> 16);
        // stage 4
        carry_reg[4] <= carry_reg[3];
        inside4_reg  <= inside_next;
        wx4_reg      <= 31'(wx_full);
        wy4_reg      <= 31'(wy_full);
        gtx4_reg     <= wx_full > WW'(carry_reg[3].speed);
        gty4_reg     <= wy_full > WW'(carry_reg[3].speed);
        // stage 5: squared gain results against squared speed
        carry_reg[5] <= carry_reg[4];
        inside5_reg  <= inside4_reg;
        wx5_reg      <= wx4_reg;
        wy5_reg      <= wy4_reg;
        gtx5_reg     <= gtx4_reg;
        gty5_reg     <= gty4_reg;
        wx25_reg     <= 62'(wx4_reg) * 62'(wx4_reg);
        wy25_reg     <= 62'(wy4_reg) * 62'(wy4_reg);
        s25_reg      <= 62'(carry_reg[4].speed) * 62'(carry_reg[4].speed);
        // stage 6
        ctrl6_reg <= ctrl_next;
        a6_reg    <= carry_reg[5].a;
        b6_reg    <= carry_reg[5].b;
    end

    assign out_valid = vld_reg[5];
    assign out_ctrl  = ctrl6_reg;
    assign out_a     = a6_reg;
    assign out_b     = b6_reg;

endmodule

`default_nettype wire

### rtl/core/ssfa_scale.sv
// Length normalizer: shift, square root and two dividers, then velocity select.
`default_nettype none

module ssfa_scale #(
    parameter int W = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ssfa_pkg::ctrl_t in_ctrl,
    input  wire logic [W:0]      in_a,
    input  wire logic [W:0]      in_b,
    output logic                 out_valid,
    output ssfa_pkg::res_t       out_res
);
    import ssfa_pkg::*;

    localparam int MW = W + 1;
    localparam int PW = $clog2(MW);
    localparam int SW = (MW > 30) ? MW : 30;

    typedef struct packed {
        ctrl_t                 ctrl;
        logic                  zero;
        logic [WIDE_BITS-1:0]  px;
        logic [WIDE_BITS-1:0]  py;
    } sq_carry_t;

    typedef struct packed {
        ctrl_t                 ctrl;
        logic                  zero;
        logic [ROOT_BITS-1:0]  len;
    } dv_carry_t;

    // Shift stages
    logic                 v1_reg, v2_reg, v3_reg;
    ctrl_t                ctrl1_reg, ctrl2_reg;
    logic                 zero1_reg, zero2_reg;
    logic [MW-1:0]        a1_reg, b1_reg;
    logic [PW-1:0]        p1_reg, p_next;
    logic [MW-1:0]        ab_or;
    logic [29:0]          a2_reg, b2_reg, a2_next, b2_next;

    // Square root pipeline
    logic                 sv_reg   [0:ROOT_BITS];
    sq_carry_t            sc_reg   [0:ROOT_BITS];
    logic [WIDE_BITS-1:0] rem_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [0:ROOT_BITS];

    // Divider pipeline
    logic                 dv_reg   [0:QUOT_BITS];
    dv_carry_t            dc_reg   [0:QUOT_BITS];
    logic [WIDE_BITS-1:0] rx_reg   [0:QUOT_BITS];
    logic [WIDE_BITS-1:0] ry_reg   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] qx_reg   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] qy_reg   [0:QUOT_BITS];

    logic                 vo_reg;
    res_t                 res_reg, res_next;
    ctrl_t                fc;

    // Leading one of the larger magnitude
    assign ab_or = in_a | in_b;
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (ab_or[i])
            begin
                p_next = PW'(i);
            end
        end
    end

    // Bring the larger magnitude into [2^29, 2^30)
    always_comb
    begin
        if (int'(p1_reg) >= 30)
        begin
            a2_next = 30'(a1_reg >> (p1_reg - PW'(29)));
            b2_next = 30'(b1_reg >> (p1_reg - PW'(29)));
        end
        else
        begin
            a2_next = 30'(SW'(a1_reg) << (PW'(29) - p1_reg));
            b2_next = 30'(SW'(b1_reg) << (PW'(29) - p1_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl1_reg <= in_ctrl;
        zero1_reg <= (ab_or == '0);
        a1_reg    <= in_a;
        b1_reg    <= in_b;
        p1_reg    <= p_next;
        ctrl2_reg <= ctrl1_reg;
        zero2_reg <= zero1_reg;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        // squared length and numerators
        sc_reg[0].ctrl <= ctrl2_reg;
        sc_reg[0].zero <= zero2_reg;
        sc_reg[0].px   <= WIDE_BITS'(a2_reg) * WIDE_BITS'(ctrl2_reg.speed);
        sc_reg[0].py   <= WIDE_BITS'(b2_reg) * WIDE_BITS'(ctrl2_reg.speed);
        rem_reg[0]     <= WIDE_BITS'(a2_reg) * WIDE_BITS'(a2_reg) +
                          WIDE_BITS'(b2_reg) * WIDE_BITS'(b2_reg);
        root_reg[0]    <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end
    assign sv_reg[0] = v3_reg;

    // One root bit per stage, most significant first
    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        localparam int K = ROOT_BITS - 1 - j;
        logic [WIDE_BITS-1:0] trial;
        assign trial = (WIDE_BITS'(root_reg[j]) << (K + 1)) | (WIDE_BITS'(1) << (2 * K));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sc_reg[j+1] <= sc_reg[j];
            if (rem_reg[j] >= trial)
            begin
                rem_reg[j+1]  <= rem_reg[j] - trial;
                root_reg[j+1] <= root_reg[j] | (ROOT_BITS'(1) << K);
            end
            else
            begin
                rem_reg[j+1]  <= rem_reg[j];
                root_reg[j+1] <= root_reg[j];
            end
        end
    end

    // Divider inputs
    assign dv_reg[0]      = sv_reg[ROOT_BITS];
    assign dc_reg[0].ctrl = sc_reg[ROOT_BITS].ctrl;
    assign dc_reg[0].zero = sc_reg[ROOT_BITS].zero;
    assign dc_reg[0].len  = root_reg[ROOT_BITS];
    assign rx_reg[0]      = sc_reg[ROOT_BITS].px;
    assign ry_reg[0]      = sc_reg[ROOT_BITS].py;
    assign qx_reg[0]      = '0;
    assign qy_reg[0]      = '0;

    // One quotient bit per stage for each component
    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_div
        localparam int K = QUOT_BITS - 1 - j;
        logic [WIDE_BITS-1:0] dsub;
        assign dsub = WIDE_BITS'(dc_reg[j].len) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dc_reg[j+1] <= dc_reg[j];
            if (rx_reg[j] >= dsub)
            begin
                rx_reg[j+1] <= rx_reg[j] - dsub;
                qx_reg[j+1] <= qx_reg[j] | (QUOT_BITS'(1) << K);
            end
            else
            begin
                rx_reg[j+1] <= rx_reg[j];
                qx_reg[j+1] <= qx_reg[j];
            end
            if (ry_reg[j] >= dsub)
            begin
                ry_reg[j+1] <= ry_reg[j] - dsub;
                qy_reg[j+1] <= qy_reg[j] | (QUOT_BITS'(1) << K);
            end
            else
            begin
                ry_reg[j+1] <= ry_reg[j];
                qy_reg[j+1] <= qy_reg[j];
            end
        end
    end

    // Velocity select: scaled, gain result, or zero
    assign fc = dc_reg[QUOT_BITS].ctrl;
    always_comb
    begin
        res_next.head      = fc.head;
        res_next.in_radius = fc.in_radius;
        if (fc.use_scale && !dc_reg[QUOT_BITS].zero)
        begin
            res_next.vx = fc.sx ? -$signed(32'(qx_reg[QUOT_BITS]))
                                :  $signed(32'(qx_reg[QUOT_BITS]));
            res_next.vy = fc.sy ? -$signed(32'(qy_reg[QUOT_BITS]))
                                :  $signed(32'(qy_reg[QUOT_BITS]));
        end
        else if (fc.use_w)
        begin
            res_next.vx = fc.sx ? -$signed(32'(fc.wx)) : $signed(32'(fc.wx));
            res_next.vy = fc.sy ? -$signed(32'(fc.wy)) : $signed(32'(fc.wy));
        end
        else
        begin
            res_next.vx = '0;
            res_next.vy = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= dv_reg[QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

### rtl/core/ssfa_cordic.sv
// Heading unit: prescale, quadrant fold, 21 vectoring stages, rounding.
`default_nettype none

module ssfa_cordic (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire ssfa_pkg::res_t in_res,
    output logic                out_valid,
    output ssfa_pkg::res_t      out_res
);
    import ssfa_pkg::*;

    logic                       v1_reg, v2_reg;
    res_t                       r1_reg, r2_reg;
    logic                       nz1_reg, nz2_reg;
    logic signed [32:0]         x1_reg, y1_reg;
    logic [4:0]                 p1_reg, p_next;
    logic [30:0]                mx, my, mor;
    logic [5:0]                 sh;
    logic signed [CX_BITS-1:0]  x2_reg, y2_reg;

    logic                       cv_reg [0:CORDIC_STEPS];
    res_t                       cr_reg [0:CORDIC_STEPS];
    logic                       cn_reg [0:CORDIC_STEPS];
    logic signed [CX_BITS-1:0]  cx_reg [0:CORDIC_STEPS];
    logic signed [CX_BITS-1:0]  cy_reg [0:CORDIC_STEPS];
    logic signed [ANG_BITS-1:0] cz_reg [0:CORDIC_STEPS];

    logic signed [ANG_BITS-1:0] q_round;
    logic signed [ANG_BITS-1:0] q_clamp;
    logic                       vo_reg;
    res_t                       res_reg, res_next;

    // Leading one of the larger velocity magnitude
    assign mx  = in_res.vx[31] ? 31'(-in_res.vx) : 31'(in_res.vx);
    assign my  = in_res.vy[31] ? 31'(-in_res.vy) : 31'(in_res.vy);
    assign mor = mx | my;
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (mor[i])
            begin
                p_next = 5'(i);
            end
        end
    end

    // Scale so the larger magnitude reaches bit 40
    assign sh = 6'd40 - 6'(p1_reg);

    always_ff @(posedge clk)
    begin
        r1_reg  <= in_res;
        nz1_reg <= (in_res.vx != '0) || (in_res.vy != '0);
        x1_reg  <= -(33'(in_res.vy));
        y1_reg  <= -(33'(in_res.vx));
        p1_reg  <= p_next;
        r2_reg  <= r1_reg;
        nz2_reg <= nz1_reg;
        x2_reg  <= CX_BITS'(x1_reg) <<< sh;
        y2_reg  <= CX_BITS'(y1_reg) <<< sh;
        // fold the left half plane onto the right one
        cr_reg[0] <= r2_reg;
        cn_reg[0] <= nz2_reg;
        if (x2_reg < 0)
        begin
            cx_reg[0] <= -x2_reg;
            cy_reg[0] <= -y2_reg;
            cz_reg[0] <= (y2_reg >= 0) ? PI_ANG : -PI_ANG;
        end
        else
        begin
            cx_reg[0] <= x2_reg;
            cy_reg[0] <= y2_reg;
            cz_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            cv_reg[0] <= v2_reg;
        end
    end

    // Vectoring iterations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [ANG_BITS-1:0] step;
        assign step = $signed(ANG_BITS'(atan_entry(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            cr_reg[i+1] <= cr_reg[i];
            cn_reg[i+1] <= cn_reg[i];
            if (cy_reg[i] > 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + step;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - step;
            end
        end
    end

    // Round half up to Q3.13 and clamp
    assign q_round = (cz_reg[CORDIC_STEPS] + $signed(ANG_BITS'(128))) >>> 8;
    always_comb
    begin
        if (q_round > ANG_BITS'(HEAD_MAX))
        begin
            q_clamp = ANG_BITS'(HEAD_MAX);
        end
        else if (q_round < -ANG_BITS'(HEAD_MAX))
        begin
            q_clamp = -ANG_BITS'(HEAD_MAX);
        end
        else
        begin
            q_clamp = q_round;
        end
        res_next      = cr_reg[CORDIC_STEPS];
        if (cn_reg[CORDIC_STEPS])
        begin
            res_next.head = 16'(q_clamp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

### rtl/core/steering_seek_flee_arrive.sv
// Depth: 97 register stages lie between the accepting edge and the result strobe.
// Throughput: one request per cycle; the square root and the two dividers are
// fully pipelined at one bit per stage, the heading unit at one iteration per stage.
// busy stays low and configuration writes are always ready.
// Reset clears all valid bits and loads radius 2.0 and gain 4.0; no result is lost to stalls.
`default_nettype none

module steering_seek_flee_arrive #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    command,
    input  wire logic signed [COORD_WIDTH-1:0] agent_x,
    input  wire logic signed [COORD_WIDTH-1:0] agent_y,
    input  wire logic signed [COORD_WIDTH-1:0] target_x,
    input  wire logic signed [COORD_WIDTH-1:0] target_y,
    input  wire logic [30:0]                   max_speed,
    input  wire logic signed [15:0]            current_heading,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [30:0]                   cfg_data,
    output logic                               result_valid,
    output logic signed [31:0]                 vel_x,
    output logic signed [31:0]                 vel_y,
    output logic signed [15:0]                 new_heading,
    output logic                               inside_radius
);
    import ssfa_pkg::*;

    logic [30:0]        radius_reg, gain_reg;
    logic               fv, sv, cv;
    ctrl_t              fctrl;
    logic [COORD_WIDTH:0] fa, fb;
    res_t               sres, cres;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ARRIVE_RADIUS: radius_reg <= cfg_data;
                REG_ARRIVE_GAIN:   gain_reg   <= cfg_data;
                default:           radius_reg <= radius_reg;
            endcase
        end
    end

    ssfa_front #(.W(COORD_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .cmd      (command),
        .ax       (agent_x),
        .ay       (agent_y),
        .tx       (target_x),
        .ty       (target_y),
        .speed    (max_speed),
        .head     (current_heading),
        .radius   (radius_reg),
        .gain     (gain_reg),
        .out_valid(fv),
        .out_ctrl (fctrl),
        .out_a    (fa),
        .out_b    (fb)
    );

    ssfa_scale #(.W(COORD_WIDTH)) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fv),
        .in_ctrl  (fctrl),
        .in_a     (fa),
        .in_b     (fb),
        .out_valid(sv),
        .out_res  (sres)
    );

    ssfa_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sv),
        .in_res   (sres),
        .out_valid(cv),
        .out_res  (cres)
    );

    assign result_valid  = cv;
    assign vel_x         = cres.vx;
    assign vel_y         = cres.vy;
    assign new_heading   = cres.head;
    assign inside_radius = cres.in_radius;

    // Inside the radius the velocity is zero
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && inside_radius) |-> (vel_x == '0 && vel_y == '0))
        else $error("inside_radius with nonzero velocity");

    // A computed heading stays within plus or minus pi
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (vel_x != '0 || vel_y != '0)) |->
        (new_heading <= HEAD_MAX && new_heading >= -HEAD_MAX))
        else $error("computed heading out of range");

    // Velocity magnitude is bounded by max_speed, so the most negative code never shows
    a_vel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (vel_x != 32'sh8000_0000 && vel_y != 32'sh8000_0000))
        else $error("velocity component overflow");

endmodule

`default_nettype wire

### dv/steering_seek_flee_arrive_tb.sv
// Self-checking testbench for the seek/flee/arrive steering block.
`timescale 1ns / 1ps

module steering_seek_flee_arrive_tb;
    import ssfa_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int LATENCY     = 97;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [30:0]        spd;
        logic signed [15:0] hd;
    } steer_req_t;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [15:0] hd;
        logic               ins;
    } steer_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          command = '0;
    logic signed [31:0]  agent_x = '0;
    logic signed [31:0]  agent_y = '0;
    logic signed [31:0]  target_x = '0;
    logic signed [31:0]  target_y = '0;
    logic [30:0]         max_speed = '0;
    logic signed [15:0]  current_heading = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [30:0]         cfg_data = '0;
    logic                result_valid;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic signed [15:0]  new_heading;
    logic                inside_radius;

    steer_req_t pending_reqs[$];
    steer_out_t expected_outs[$];
    longint unsigned model_radius = RADIUS_RESET;
    longint unsigned model_gain   = GAIN_RESET;
    logic  took = 1'b0;
    int    gap_left = 0;
    bit    burst = 1'b0;
    int    burst_left = 0;
    int    errors = 0;
    int    results_seen = 0;
    int    inside_seen = 0;
    int    cycles = 0;
    int    cfg_writes = 0;
    longint unsigned cur_radius = RADIUS_RESET;

    steering_seek_flee_arrive i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .agent_x(agent_x), .agent_y(agent_y),
        .target_x(target_x), .target_y(target_y), .max_speed(max_speed),
        .current_heading(current_heading),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid), .vel_x(vel_x), .vel_y(vel_y),
        .new_heading(new_heading), .inside_radius(inside_radius)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint signed_mag(longint ref_v, longint unsigned m);
        return ref_v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // normalize offset and scale its length to speed s
    function automatic void scale_to_speed(input longint dx, input longint dy,
                                           input longint unsigned s,
                                           output longint vx, output longint vy);
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        longint unsigned len;
        a = abs64(dx);
        b = abs64(dy);
        m = a > b ? a : b;
        if (m == 0)
        begin
            vx = 0;
            vy = 0;
        end
        else
        begin
            while (m >= (64'd1 << 30)) begin a = a >> 1; b = b >> 1; m = m >> 1; end
            while (m < (64'd1 << 29)) begin a = a << 1; b = b << 1; m = m << 1; end
            len = int_sqrt(a * a + b * b);
            vx = signed_mag(dx, a * s / len);
            vy = signed_mag(dy, b * s / len);
        end
    endfunction

    function automatic logic [22:0] atan_step(int i);
        case (i)
            0: return 23'd1647099;   1: return 23'd972340;   2: return 23'd513757;
            3: return 23'd260791;    4: return 23'd130902;   5: return 23'd65515;
            6: return 23'd32765;     7: return 23'd16384;    8: return 23'd8192;
            9: return 23'd4096;      10: return 23'd2048;    11: return 23'd1024;
            12: return 23'd512;      13: return 23'd256;     14: return 23'd128;
            15: return 23'd64;       16: return 23'd32;      17: return 23'd16;
            18: return 23'd8;        19: return 23'd4;       default: return 23'd2;
        endcase
    endfunction

    // heading = atan2(-vx, -vy) by CORDIC vectoring, rounded to Q3.13
    function automatic logic signed [15:0] heading_from(longint vx, longint vy);
        longint x;
        longint y;
        longint z;
        longint base;
        longint xs;
        longint ys;
        longint q;
        longint unsigned m;
        y = -vx;
        x = -vy;
        z = 0;
        base = 0;
        m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        while (m < (64'd1 << 40)) begin x = x * 2; y = y * 2; m = m << 1; end
        if (x < 0)
        begin
            base = y >= 0 ? longint'(PI_ANG) : -longint'(PI_ANG);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (y > 0) begin x = x + xs; y = y - ys; z = z + longint'(atan_step(i)); end
            else       begin x = x - xs; y = y + ys; z = z - longint'(atan_step(i)); end
        end
        q = ((base + z + 128 + (64'sd1 <<< 30)) >>> 8) - (64'sd1 <<< 22);
        if (q > HEAD_MAX) q = HEAD_MAX;
        if (q < -HEAD_MAX) q = -HEAD_MAX;
        return q[15:0];
    endfunction

    function automatic longint unsigned gain_mul(longint unsigned a, longint unsigned g);
        return (a >> 16) * g + (((a & 64'hFFFF) * g) >> 16);
    endfunction

    function automatic steer_out_t predict_steer(steer_req_t r);
        steer_out_t o;
        longint dx;
        longint dy;
        longint vx;
        longint vy;
        longint unsigned a;
        longint unsigned b;
        longint unsigned s;
        longint unsigned wx;
        longint unsigned wy;
        dx = longint'(r.tx) - longint'(r.ax);
        dy = longint'(r.ty) - longint'(r.ay);
        s = r.spd;
        vx = 0;
        vy = 0;
        o.ins = 1'b0;
        o.hd = r.hd;
        case (r.cmd)
            CMD_SEEK: scale_to_speed(dx, dy, s, vx, vy);
            CMD_FLEE: scale_to_speed(-dx, -dy, s, vx, vy);
            CMD_ARRIVE:
            begin
                a = abs64(dx);
                b = abs64(dy);
                if (a < model_radius && b < model_radius
                    && a * a + b * b < model_radius * model_radius)
                    o.ins = 1'b1;
                else
                begin
                    wx = gain_mul(a, model_gain);
                    wy = gain_mul(b, model_gain);
                    if (wx > s || wy > s || wx * wx + wy * wy > s * s)
                        scale_to_speed(dx, dy, s, vx, vy);
                    else
                    begin
                        vx = signed_mag(dx, wx);
                        vy = signed_mag(dy, wy);
                    end
                end
            end
            default: ;
        endcase
        if (vx != 0 || vy != 0)
            o.hd = heading_from(vx, vy);
        o.vx = vx[31:0];
        o.vy = vy[31:0];
        return o;
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        steer_req_t r;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took)
            ;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            r = pending_reqs.pop_front();
            command <= r.cmd;
            agent_x <= r.ax;
            agent_y <= r.ay;
            target_x <= r.tx;
            target_y <= r.ty;
            max_speed <= r.spd;
            current_heading <= r.hd;
            start <= 1'b1;
            // alternate between back-to-back bursts and random gaps
            if (burst_left == 0)
            begin
                burst <= ($urandom_range(0, 3) == 0);
                burst_left <= $urandom_range(10, 60);
            end
            else
                burst_left <= burst_left - 1;
            gap_left <= burst ? 0 : $urandom_range(0, 8);
        end
        else
            start <= 1'b0;
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        steer_req_t r;
        steer_out_t e;
        took <= rst_n && start && !busy;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ARRIVE_RADIUS) model_radius = cfg_data;
            else model_gain = cfg_data;
        end
        if (rst_n && start && !busy)
        begin
            r.cmd = command; r.ax = agent_x; r.ay = agent_y; r.tx = target_x;
            r.ty = target_y; r.spd = max_speed; r.hd = current_heading;
            expected_outs.push_back(predict_steer(r));
        end
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_outs.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending", $time);
            end
            else
            begin
                e = expected_outs.pop_front();
                if (e.ins) inside_seen++;
                if (vel_x !== e.vx)
                begin
                    errors++;
                    $display("%0t: vel_x exp %0d got %0d", $time, e.vx, vel_x);
                end
                if (vel_y !== e.vy)
                begin
                    errors++;
                    $display("%0t: vel_y exp %0d got %0d", $time, e.vy, vel_y);
                end
                if (new_heading !== e.hd)
                begin
                    errors++;
                    $display("%0t: new_heading exp %0d got %0d", $time, e.hd, new_heading);
                end
                if (inside_radius !== e.ins)
                begin
                    errors++;
                    $display("%0t: inside_radius exp %0d got %0d", $time, e.ins,
                             inside_radius);
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_req(logic [1:0] c, longint ax, longint ay, longint tx, longint ty,
                           longint unsigned spd, logic signed [15:0] hd);
        steer_req_t r;
        r.cmd = c; r.ax = ax[31:0]; r.ay = ay[31:0]; r.tx = tx[31:0]; r.ty = ty[31:0];
        r.spd = spd[30:0]; r.hd = hd;
        pending_reqs.push_back(r);
    endtask

    function automatic longint rand_off(longint unsigned span);
        longint v;
        v = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
        return v;
    endfunction

    task automatic add_random();
        logic [1:0] c;
        longint ax;
        longint ay;
        longint dx;
        longint dy;
        longint unsigned spd;
        logic signed [15:0] hd;
        int k;
        k = $urandom_range(0, 19);
        c = k < 6 ? CMD_SEEK : k < 12 ? CMD_FLEE : k < 19 ? CMD_ARRIVE : 2'd3;
        ax = $signed($urandom);
        ay = $signed($urandom);
        case ($urandom_range(0, 4))
            0:
            begin
                dx = longint'($signed($urandom)) - ax;
                dy = longint'($signed($urandom)) - ay;
            end
            1:
            begin
                dx = rand_off(64'd1 << $urandom_range(0, 26));
                dy = rand_off(64'd1 << $urandom_range(0, 26));
            end
            2, 3:
            begin
                // around the arrive radius
                dx = rand_off(2 * cur_radius + 4);
                dy = rand_off(2 * cur_radius + 4);
            end
            default:
            begin
                dx = $urandom_range(0, 2) == 0 ? 0 : rand_off(64'd1 << 20);
                dy = $urandom_range(0, 2) == 0 ? 0 : rand_off(64'd1 << 20);
            end
        endcase
        // keep the target on the 32-bit grid
        if (ax + dx > 64'sh7FFFFFFF || ax + dx < -64'sh80000000) dx = -dx;
        if (ay + dy > 64'sh7FFFFFFF || ay + dy < -64'sh80000000) dy = -dy;
        case ($urandom_range(0, 5))
            0: spd = $urandom & 32'h7FFFFFFF;
            1: spd = 0;
            2: spd = 31'h7FFFFFFF;
            default: spd = $urandom_range(0, 1 << 24);
        endcase
        hd = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
        add_req(c, ax, ay, ax + dx, ay + dy, spd, hd);
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == REG_ARRIVE_RADIUS) cur_radius = val;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || start || expected_outs.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        longint mx;
        longint mn;
        mx = 64'sh7FFFFFFF;
        mn = -64'sh80000000;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed cases with reset register values
        add_req(CMD_SEEK,   0, 0, 65536, 0, 65536, 0);
        add_req(CMD_FLEE,   0, 0, 65536, 65536, 131072, 100);
        add_req(CMD_SEEK,   5, 5, 5, 5, 65536, 1234);         // zero offset
        add_req(CMD_FLEE,   -7, 9, -7, 9, 65536, -1234);      // zero offset
        add_req(CMD_SEEK,   0, 0, 1000, 1000, 0, 777);        // zero speed
        add_req(CMD_ARRIVE, 0, 0, 65536, 65536, 1 << 20, 5);  // inside radius
        add_req(CMD_ARRIVE, 0, 0, 131072, 0, 1 << 30, 5);     // on radius edge
        add_req(CMD_ARRIVE, 0, 0, 200000, -150000, 1 << 30, 5); // gain, no clamp
        add_req(CMD_ARRIVE, 0, 0, 1 << 24, 1 << 24, 65536, 5);  // clamped
        add_req(2'd3,       0, 0, 1 << 20, 1 << 20, 65536, 321); // unused command
        add_req(CMD_SEEK,   0, 0, 0, 0, 65536, 16'sh7FFF);   // heading out of range
        add_req(CMD_FLEE,   1, 1, 1, 1, 65536, 16'sh8000);
        add_req(CMD_SEEK,   mn, mn, mx, mx, 31'h7FFFFFFF, 0);
        add_req(CMD_FLEE,   mn, mx, mx, mn, 31'h7FFFFFFF, 0);
        add_req(CMD_ARRIVE, mx, mx, mn, mn, 31'h7FFFFFFF, 0);
        add_req(CMD_SEEK,   0, 0, 0, 65536, 65536, 0);        // straight axes
        add_req(CMD_SEEK,   0, 0, 0, -65536, 65536, 0);
        add_req(CMD_SEEK,   0, 0, 65536, 0, 65536, 0);
        add_req(CMD_SEEK,   0, 0, -65536, 0, 65536, 0);
        add_req(CMD_SEEK,   0, 0, 1, -1, 1, 25736);
        add_req(CMD_ARRIVE, 0, 0, mx, 0, 31'h7FFFFFFF, -25736);
        repeat (200) add_random();
        wait_idle();

        // zero radius and gain
        write_reg(REG_ARRIVE_RADIUS, 31'd0);
        write_reg(REG_ARRIVE_GAIN, 31'd0);
        add_req(CMD_ARRIVE, 3, 3, 3, 3, 65536, 99);
        repeat (200) add_random();
        wait_idle();

        // largest radius and gain
        write_reg(REG_ARRIVE_RADIUS, 31'h7FFFFFFF);
        write_reg(REG_ARRIVE_GAIN, 31'h7FFFFFFF);
        repeat (200) add_random();
        wait_idle();

        // random settings
        write_reg(REG_ARRIVE_RADIUS, 31'($urandom_range(0, 1 << 22)));
        write_reg(REG_ARRIVE_GAIN, 31'($urandom & 32'h7FFFFFFF));
        repeat (200) add_random();
        wait_idle();

        // typical settings: fractional gain
        write_reg(REG_ARRIVE_RADIUS, 31'd1 << 20);
        write_reg(REG_ARRIVE_GAIN, 31'd1 << 15);
        repeat (230) add_random();
        wait_idle();

        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d results (%0d inside radius) over %0d register writes.",
                 results_seen, inside_seen, cfg_writes);
        $display("Commands seek/flee/arrive/unused with zero, extreme and random offsets.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
